/* design/pxansi_pkg.sv */
`timescale 1ns / 1ps

package pxansi_pkg;

   localparam int unsigned QueueDepthDefault = 4;

   localparam logic [4:0] PosPrefixFirst = 5'd0;
   localparam logic [4:0] PosPrefixLast  = 5'd6;
   localparam logic [4:0] PosRed         = 5'd7;
   localparam logic [4:0] PosSemiGreen   = 5'd10;
   localparam logic [4:0] PosGreen       = 5'd11;
   localparam logic [4:0] PosSemiBlue    = 5'd14;
   localparam logic [4:0] PosBlue        = 5'd15;
   localparam logic [4:0] PosFinalM      = 5'd18;
   localparam logic [4:0] PosGlyph       = 5'd19;

   localparam logic [7:0] CharEsc   = 8'h1b;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharSemi  = 8'h3b;
   localparam logic [7:0] CharM     = 8'h6d;
   localparam logic [7:0] CharZero  = 8'h30;

   typedef struct packed {
      logic        esc;
      logic [11:0] red_bcd;
      logic [11:0] green_bcd;
      logic [11:0] blue_bcd;
      logic [1:0]  red_skip;
      logic [1:0]  green_skip;
      logic [1:0]  blue_skip;
      logic [7:0]  glyph;
   } cmd_type;

   function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0: b = CharEsc;
         3'd1: b = 8'h5b;
         3'd2: b = 8'h33;
         3'd3: b = 8'h38;
         3'd4: b = CharSemi;
         3'd5: b = 8'h32;
         3'd6: b = CharSemi;
         default: b = CharSemi;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] ramp_char(input logic [4:0] idx);
      logic [7:0] c;
      unique case (idx)
         5'd0:  c = 8'h20; // ' '
         5'd1:  c = 8'h2d; // '-'
         5'd2:  c = 8'h3a; // ':'
         5'd3:  c = 8'h3d; // '='
         5'd4:  c = 8'h2b; // '+'
         5'd5:  c = 8'h3c; // '<'
         5'd6:  c = 8'h29; // ')'
         5'd7:  c = 8'h25; // '%'
         5'd8:  c = 8'h7d; // '}'
         5'd9:  c = 8'h49; // 'I'
         5'd10: c = 8'h63; // 'c'
         5'd11: c = 8'h73; // 's'
         5'd12: c = 8'h37; // '7'
         5'd13: c = 8'h66; // 'f'
         5'd14: c = 8'h6e; // 'n'
         5'd15: c = 8'h43; // 'C'
         5'd16: c = 8'h6f; // 'o'
         5'd17: c = 8'h33; // '3'
         5'd18: c = 8'h77; // 'w'
         5'd19: c = 8'h6d; // 'm'
         5'd20: c = 8'h53; // 'S'
         5'd21: c = 8'h64; // 'd'
         5'd22: c = 8'h36; // '6'
         5'd23: c = 8'h56; // 'V'
         5'd24: c = 8'h41; // 'A'
         5'd25: c = 8'h58; // 'X'
         5'd26: c = 8'h55; // 'U'
         5'd27: c = 8'h4b; // 'K'
         5'd28: c = 8'h38; // '8'
         5'd29: c = 8'h52; // 'R'
         5'd30: c = 8'h40; // '@'
         5'd31: c = 8'h51; // 'Q'
         default: c = CharSpace;
      endcase
      return c;
   endfunction

   // shift-add-3 conversion, eight narrow steps
   function automatic logic [11:0] to_bcd(input logic [7:0] v);
      logic [19:0] acc;
      acc = {12'd0, v};
      for (int i = 0; i < 8; i++) begin
         if (acc[11:8] >= 4'd5) begin
            acc[11:8] = acc[11:8] + 4'd3;
         end
         if (acc[15:12] >= 4'd5) begin
            acc[15:12] = acc[15:12] + 4'd3;
         end
         if (acc[19:16] >= 4'd5) begin
            acc[19:16] = acc[19:16] + 4'd3;
         end
         acc = acc << 1;
      end
      return acc[19:8];
   endfunction

   function automatic logic [1:0] digit_skip(input logic [7:0] v);
      logic [1:0] s;
      if (v >= 8'd100) begin
         s = 2'd0;
      end else if (v >= 8'd10) begin
         s = 2'd1;
      end else begin
         s = 2'd2;
      end
      return s;
   endfunction

endpackage

/* design/pxansi_front.sv */
`timescale 1ns / 1ps

module pxansi_front
   import pxansi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       frame_start,
   input  logic [7:0] red,
   input  logic [7:0] green,
   input  logic [7:0] blue,
   input  logic [7:0] lum_a,
   input  logic [7:0] lum_b,
   input  logic [7:0] lum_c,
   input  logic [7:0] lum_d,
   input  logic [7:0] lum_e,
   input  logic [7:0] lum_f,
   input  logic [7:0] lum_g,
   input  logic [7:0] lum_h,
   output cmd_type    cmd
);

   logic [23:0] prev_colour_ff, prev_colour_in;
   logic        prev_valid_ff, prev_valid_in;
   logic [23:0] colour;
   logic [10:0] lum_sum;
   logic        black;
   logic        valid_eff;
   logic        esc;

   always_comb begin
      colour    = {red, green, blue};
      black     = (colour == 24'd0);
      valid_eff = prev_valid_ff & ~frame_start;
      esc       = ~black & (~valid_eff | (prev_colour_ff != colour));
      lum_sum   = {3'd0, lum_a} + {3'd0, lum_b} + {3'd0, lum_c} + {3'd0, lum_d}
                + {3'd0, lum_e} + {3'd0, lum_f} + {3'd0, lum_g} + {3'd0, lum_h};

      cmd.esc        = esc;
      cmd.red_bcd    = to_bcd(red);
      cmd.green_bcd  = to_bcd(green);
      cmd.blue_bcd   = to_bcd(blue);
      cmd.red_skip   = digit_skip(red);
      cmd.green_skip = digit_skip(green);
      cmd.blue_skip  = digit_skip(blue);
      cmd.glyph      = black ? CharSpace : ramp_char(lum_sum[10:6]);

      prev_colour_in = prev_colour_ff;
      prev_valid_in  = prev_valid_ff;
      if (accept) begin
         if (esc) begin
            prev_colour_in = colour;
            prev_valid_in  = 1'b1;
         end else begin
            prev_valid_in  = valid_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_colour_ff <= 24'd0;
         prev_valid_ff  <= 1'b0;
      end else begin
         prev_colour_ff <= prev_colour_in;
         prev_valid_ff  <= prev_valid_in;
      end
   end

endmodule

/* design/pxansi_queue.sv */
`timescale 1ns / 1ps

module pxansi_queue
   import pxansi_pkg::*;
#(
   parameter int unsigned Depth = QueueDepthDefault
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head
);

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);

   cmd_type               mem [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   always_comb begin
      full    = (count_ff == CntFull);
      empty   = (count_ff == '0);
      head    = mem[rd_ptr_ff];
      do_push = push & ~full;
      do_pop  = pop & ~empty;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* design/pxansi_back.sv */
`timescale 1ns / 1ps

module pxansi_back
   import pxansi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_empty,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   output logic       out_empty,
   input  logic       out_pop,
   output logic [7:0] out_byte,
   output logic       out_last
);

   logic [4:0] pos_ff, pos_in;
   logic       first_ff, first_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;
   logic [4:0] pos;
   logic [4:0] pos_next;
   logic [4:0] rel;
   logic [7:0] byte_sel;
   logic       slot_free;
   logic       emit;

   function automatic logic [7:0] digit_char(input logic [11:0] bcd, input logic [4:0] idx);
      logic [3:0] d;
      unique case (idx[1:0])
         2'd0:    d = bcd[11:8];
         2'd1:    d = bcd[7:4];
         default: d = bcd[3:0];
      endcase
      return CharZero + {4'd0, d};
   endfunction

   always_comb begin
      pos = first_ff ? (cmd.esc ? PosPrefixFirst : PosGlyph) : pos_ff;

      priority if (pos == PosPrefixLast) begin
         pos_next = PosRed + {3'd0, cmd.red_skip};
      end else if (pos == PosSemiGreen) begin
         pos_next = PosGreen + {3'd0, cmd.green_skip};
      end else if (pos == PosSemiBlue) begin
         pos_next = PosBlue + {3'd0, cmd.blue_skip};
      end else begin
         pos_next = pos + 5'd1;
      end

      rel = 5'd0;
      priority if (pos <= PosPrefixLast) begin
         byte_sel = prefix_byte(pos[2:0]);
      end else if (pos < PosSemiGreen) begin
         rel      = pos - PosRed;
         byte_sel = digit_char(cmd.red_bcd, rel);
      end else if (pos == PosSemiGreen) begin
         byte_sel = CharSemi;
      end else if (pos < PosSemiBlue) begin
         rel      = pos - PosGreen;
         byte_sel = digit_char(cmd.green_bcd, rel);
      end else if (pos == PosSemiBlue) begin
         byte_sel = CharSemi;
      end else if (pos < PosFinalM) begin
         rel      = pos - PosBlue;
         byte_sel = digit_char(cmd.blue_bcd, rel);
      end else if (pos == PosFinalM) begin
         byte_sel = CharM;
      end else begin
         byte_sel = cmd.glyph;
      end

      slot_free = ~out_valid_ff | out_pop;
      emit      = slot_free & ~cmd_empty;
      cmd_pop   = emit & (pos == PosGlyph);

      pos_in       = pos_ff;
      first_in     = first_ff;
      out_valid_in = out_valid_ff & ~out_pop;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = byte_sel;
         out_last_in  = (pos == PosGlyph);
         if (pos == PosGlyph) begin
            first_in = 1'b1;
         end else begin
            first_in = 1'b0;
            pos_in   = pos_next;
         end
      end

      out_empty = ~out_valid_ff;
      out_byte  = out_byte_ff;
      out_last  = out_last_ff;
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      pos_ff      <= pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         first_ff     <= first_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

/* design/pixel_cell_to_ansi_text_encoder.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake       Payload
// req_      in         push / full     frame_start, red, green, blue, lum_a .. lum_h
// rsp_      out        pop / empty     text_byte, last_byte
//
// One text byte leaves per cycle from the output register while rsp_pop is high
// and a cell is queued; a cell gives 1 byte (space or repeated colour) up to 20
// bytes (escape sequence plus glyph). A cell enters the command queue in the
// cycle it is accepted. Reset is synchronous, active high, and empties the queue
// and output register and forgets the last colour. full rises only when the
// command queue holds QueueDepth cells; rsp_pop low holds the output byte.

module pixel_cell_to_ansi_text_encoder
   import pxansi_pkg::*;
#(
   parameter int unsigned QueueDepth = QueueDepthDefault
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_frame_start,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   input  logic [7:0] req_lum_a,
   input  logic [7:0] req_lum_b,
   input  logic [7:0] req_lum_c,
   input  logic [7:0] req_lum_d,
   input  logic [7:0] req_lum_e,
   input  logic [7:0] req_lum_f,
   input  logic [7:0] req_lum_g,
   input  logic [7:0] req_lum_h,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_text_byte,
   output logic       rsp_last_byte
);

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    accept;
   logic    queue_full;
   logic    queue_empty;
   logic    queue_pop;

   assign accept   = req_push & ~queue_full;
   assign req_full = queue_full;

   pxansi_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_start (req_frame_start),
      .red         (req_red),
      .green       (req_green),
      .blue        (req_blue),
      .lum_a       (req_lum_a),
      .lum_b       (req_lum_b),
      .lum_c       (req_lum_c),
      .lum_d       (req_lum_d),
      .lum_e       (req_lum_e),
      .lum_f       (req_lum_f),
      .lum_g       (req_lum_g),
      .lum_h       (req_lum_h),
      .cmd         (front_cmd)
   );

   pxansi_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_cmd (front_cmd),
      .pop      (queue_pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head     (head_cmd)
   );

   pxansi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (queue_empty),
      .cmd       (head_cmd),
      .cmd_pop   (queue_pop),
      .out_empty (rsp_empty),
      .out_pop   (rsp_pop),
      .out_byte  (rsp_text_byte),
      .out_last  (rsp_last_byte)
   );

endmodule
